/* design/record_header_parser_core_assert.svh */
// assertion macros for the record header parser core
// used by record_header_parser_core.sv, no other dependencies
`ifndef RECORD_HEADER_PARSER_CORE_ASSERT_SVH
`define RECORD_HEADER_PARSER_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define RHP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define RHP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/rhp_pkg.sv */
// types, codes and type tables for the record header parser
// no dependencies
package rhp_pkg;

  localparam int unsigned RecHeadBytes = 16;

  typedef enum logic [1:0] {
    KIND_VALUE = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_ERROR = 2'd2
  } rhp_kind_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_TRUNCATED = 3'd1,
    ERR_BAD_LEN   = 3'd2,
    ERR_TOO_LONG  = 3'd3,
    ERR_NAME      = 3'd4,
    ERR_BAD_TYPE  = 3'd5
  } rhp_err_e;

  typedef enum logic [3:0] {
    TYPE_UNKNOWN = 4'd0,
    TYPE_I8      = 4'd1,
    TYPE_I32     = 4'd2,
    TYPE_I16     = 4'd3,
    TYPE_F32     = 4'd4,
    TYPE_F64     = 4'd5,
    TYPE_TEXT    = 4'd6,
    TYPE_C64     = 4'd7,
    TYPE_I64     = 4'd8
  } rhp_type_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } rhp_in_t;

  typedef struct packed {
    rhp_kind_e   result_kind;
    logic [63:0] item_name;
    rhp_type_e   item_type;
    logic [63:0] item_value;
    logic [5:0]  value_index;
    logic        record_end;
    rhp_err_e    error_code;
  } rhp_out_t;

  // one request's outcome from the parse step
  typedef struct packed {
    logic     valid;
    rhp_out_t data;
  } rhp_res_t;

  // bytes per value
  function automatic logic [3:0] rhp_type_size(rhp_type_e t);
    logic [3:0] s;
    unique case (t)
      TYPE_I8:   s = 4'd1;
      TYPE_I32:  s = 4'd4;
      TYPE_I16:  s = 4'd2;
      TYPE_F32:  s = 4'd4;
      TYPE_F64:  s = 4'd8;
      TYPE_TEXT: s = 4'd1;
      TYPE_C64:  s = 4'd8;
      TYPE_I64:  s = 4'd8;
      default:   s = 4'd0;
    endcase
    return s;
  endfunction

  // data alignment in bytes
  function automatic logic [3:0] rhp_type_align(rhp_type_e t);
    logic [3:0] a;
    unique case (t)
      TYPE_I8:   a = 4'd1;
      TYPE_I32:  a = 4'd4;
      TYPE_I16:  a = 4'd2;
      TYPE_F32:  a = 4'd4;
      TYPE_F64:  a = 4'd8;
      TYPE_TEXT: a = 4'd1;
      TYPE_C64:  a = 4'd4;
      TYPE_I64:  a = 4'd8;
      default:   a = 4'd0;
    endcase
    return a;
  endfunction

  // single-byte type code is reported as text
  function automatic rhp_type_e rhp_shown_type(rhp_type_e t);
    return (t == TYPE_I8) ? TYPE_TEXT : t;
  endfunction

endpackage

/* design/rhp_parse.sv */
// record parse state and per-byte step logic
// depends on rhp_pkg
module rhp_parse import rhp_pkg::*; #(
  parameter int unsigned MaxDataBytes = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     step_i,
  input  rhp_in_t  item_i,
  output rhp_res_t res_o
);

  logic [6:0]  pos_q, pos_d;
  logic [63:0] name_q, name_d;
  logic [6:0]  alen_q, alen_d;
  logic [31:0] type_q, type_d;
  logic [63:0] acc_q, acc_d;
  logic [2:0]  bcnt_q, bcnt_d;
  logic [5:0]  vdone_q, vdone_d;
  logic        halted_q, halted_d;

  logic [7:0]  b;
  logic        fin;
  logic [7:0]  pos8;
  logic [63:0] name_base;
  logic [7:0]  last_pos;
  logic [7:0]  end_pos;
  logic [31:0] type_cur;
  logic        tvalid;
  rhp_type_e   tcode;
  logic [3:0]  off;
  logic [3:0]  size;
  logic [6:0]  data_len;
  logic [63:0] acc_new;
  rhp_err_e    err;
  logic        done;

  assign b    = item_i.data_byte;
  assign fin  = item_i.final_byte;
  assign pos8 = {1'b0, pos_q};

  // record geometry from the stored length
  assign last_pos = 8'(RecHeadBytes) + {1'b0, alen_q} - 8'd1;
  assign end_pos  = 8'(RecHeadBytes) + (({1'b0, alen_q} + 8'd15) & 8'hF0) - 8'd1;

  assign type_cur = (pos_q <= 7'd19) ? {type_q[23:0], b} : type_q;
  assign tvalid   = (type_cur >= 32'd1) && (type_cur <= 32'd8);
  assign tcode    = rhp_type_e'(type_cur[3:0]);
  assign off      = (tvalid && (rhp_type_align(tcode) > 4'd4)) ? 4'd8 : 4'd4;
  assign size     = tvalid ? rhp_type_size(tcode) : 4'd0;
  assign data_len = alen_q - {3'b000, off};
  assign acc_new  = {acc_q[55:0], b};
  assign name_base = (pos_q == 7'd0) ? 64'd0 : name_q;

  always_comb begin
    pos_d    = pos_q;
    name_d   = name_q;
    alen_d   = alen_q;
    type_d   = type_q;
    acc_d    = acc_q;
    bcnt_d   = bcnt_q;
    vdone_d  = vdone_q;
    halted_d = halted_q;
    res_o    = '0;
    err      = ERR_NONE;
    done     = 1'b0;

    if (halted_q) begin
      if (fin) begin
        halted_d = 1'b0;
      end
    end else begin
      if (pos_q <= 7'd14) begin
        if (pos_q == 7'd0) begin
          alen_d  = '0;
          type_d  = '0;
          acc_d   = '0;
          bcnt_d  = '0;
          vdone_d = '0;
        end
        name_d = (pos_q < 7'd8) ? {name_base[55:0], b} : name_base;
        if (fin) begin
          err = ERR_TRUNCATED;
        end else if (pos_q == 7'd8 && b != 8'd0) begin
          err = ERR_NAME;
        end
      end else if (pos_q == 7'd15) begin
        if (b >= 8'd128 || (b >= 8'd1 && b <= 8'd4)) begin
          err = ERR_BAD_LEN;
        end else if (b > 8'(MaxDataBytes)) begin
          err = ERR_TOO_LONG;
        end else if (b == 8'd0) begin
          res_o.valid            = 1'b1;
          res_o.data.result_kind = KIND_EMPTY;
          res_o.data.item_name   = name_q;
          res_o.data.item_type   = TYPE_UNKNOWN;
          res_o.data.record_end  = 1'b1;
          done = 1'b1;
        end else begin
          alen_d = b[6:0];
          if (fin) begin
            err = ERR_TRUNCATED;
          end
        end
      end else begin
        type_d = type_cur;
        if (fin && pos8 < last_pos) begin
          err = ERR_TRUNCATED;
        end else if (pos_q == 7'd19) begin
          if (!tvalid) begin
            err = ERR_BAD_TYPE;
          end else if (alen_q < {3'b000, off}) begin
            err = ERR_BAD_LEN;
          end else if ((data_len & {3'b000, size - 4'd1}) != 7'd0) begin
            err = ERR_BAD_TYPE;
          end
        end

        if (err == ERR_NONE) begin
          if (size != 4'd0 && pos8 >= 8'(RecHeadBytes) + {4'b0000, off}
              && pos8 <= last_pos) begin
            if ({1'b0, bcnt_q} + 4'd1 >= size) begin
              res_o.valid            = 1'b1;
              res_o.data.result_kind = KIND_VALUE;
              res_o.data.item_name   = name_q;
              res_o.data.item_type   = rhp_shown_type(tcode);
              res_o.data.item_value  = acc_new;
              res_o.data.value_index = vdone_q;
              res_o.data.record_end  = (pos8 == last_pos);
              vdone_d = vdone_q + 6'd1;
              bcnt_d  = '0;
              acc_d   = '0;
            end else begin
              acc_d  = acc_new;
              bcnt_d = bcnt_q + 3'd1;
            end
          end else if (pos8 == last_pos && vdone_q == 6'd0 && size != 4'd0) begin
            // valid type but no whole value in the record
            res_o.valid            = 1'b1;
            res_o.data.result_kind = KIND_EMPTY;
            res_o.data.item_name   = name_q;
            res_o.data.item_type   = rhp_shown_type(tcode);
            res_o.data.record_end  = 1'b1;
          end
          if (pos8 >= end_pos) begin
            done = 1'b1;
          end
        end
      end

      if (err != ERR_NONE) begin
        res_o                  = '0;
        res_o.valid            = 1'b1;
        res_o.data.result_kind = KIND_ERROR;
        res_o.data.record_end  = 1'b1;
        res_o.data.error_code  = err;
        halted_d = 1'b1;
      end else if (done) begin
        pos_d = '0;
      end else begin
        pos_d = pos_q + 7'd1;
      end

      if (fin) begin
        halted_d = 1'b0;
      end
    end

    // end of stream: back to a clean start
    if (fin) begin
      pos_d   = '0;
      name_d  = '0;
      alen_d  = '0;
      type_d  = '0;
      acc_d   = '0;
      bcnt_d  = '0;
      vdone_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      name_q   <= '0;
      alen_q   <= '0;
      type_q   <= '0;
      acc_q    <= '0;
      bcnt_q   <= '0;
      vdone_q  <= '0;
      halted_q <= 1'b0;
    end else if (step_i) begin
      pos_q    <= pos_d;
      name_q   <= name_d;
      alen_q   <= alen_d;
      type_q   <= type_d;
      acc_q    <= acc_d;
      bcnt_q   <= bcnt_d;
      vdone_q  <= vdone_d;
      halted_q <= halted_d;
    end
  end

endmodule

/* design/record_header_parser_core.sv */
// a request is held in the input register; any result it gives goes to the result register
// throughput: one byte per cycle if not stalled; each byte is one rhp_parse state update
// a stalled result holds the result register; the input register still takes one request
// reset: asynchronous active low, clears parse state, halt flag and both valid flags
// depends on rhp_pkg, rhp_parse and record_header_parser_core_assert.svh
`include "record_header_parser_core_assert.svh"

module record_header_parser_core import rhp_pkg::*; #(
  parameter int unsigned MaxDataBytes = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  rhp_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output rhp_out_t out_data_o
);

  logic     in_valid_q;
  rhp_in_t  in_q;
  logic     out_valid_q;
  rhp_out_t out_q;
  logic     advance;
  logic     step;
  rhp_res_t res;

  // result slot is free or is being drained this cycle
  assign advance    = !out_valid_q || out_ready_i;
  assign step       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  rhp_parse #(
    .MaxDataBytes(MaxDataBytes)
  ) u_parse (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(step),
    .item_i(in_q),
    .res_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= step && res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res.valid) begin
      out_q <= res.data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `RHP_ASSERT_NOW(a_ready_low_only_when_full, clk_i, rst_ni,
    !in_ready_o, in_valid_q && out_valid_q && !out_ready_i,
    "input stalled while a slot is free")
  `RHP_ASSERT_NEXT(a_held_request_kept, clk_i, rst_ni,
    in_valid_q && !advance, in_valid_q && $stable(in_q),
    "pending request lost while result stalled")
  `RHP_ASSERT_NOW(a_error_ends_record, clk_i, rst_ni,
    out_valid_o && out_data_o.result_kind == KIND_ERROR,
    out_data_o.record_end && out_data_o.error_code != ERR_NONE,
    "error result without end flag or code")
  `RHP_ASSERT_NOW(a_no_code_on_data, clk_i, rst_ni,
    out_valid_o && out_data_o.result_kind != KIND_ERROR,
    out_data_o.error_code == ERR_NONE,
    "error code on a non-error result")

endmodule
